[rtl/core/nsfp_pkg.sv]
// shared types, character codes and defaults of the nmea sentence field parser
package nsfp_pkg;

    localparam int FIELD_BUFFER_DEPTH_DEF = 16;
    localparam int HEAD_DEPTH             = 6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] MASK_RESET = 2'b11;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_DOLLAR,
        PH_G,
        PH_GP,
        PH_FIELD
    } t_phase;

    typedef enum logic [1:0] {
        NS_INT,
        NS_FRAC1,
        NS_FRAC2,
        NS_DONE
    } t_num_stage;

    typedef enum logic [1:0] {
        GRP_GGA     = 2'd0,
        GRP_RMC     = 2'd1,
        GRP_UNKNOWN = 2'd2
    } t_group;

    typedef struct packed {
        t_group             group_code;
        logic [7:0]         field_index;
        logic signed [15:0] int_part;
        logic [6:0]         frac_part;
        logic [7:0]         first_char;
        logic [3:0]         field_length;
        logic [7:0]         pair_one;
        logic [7:0]         pair_two;
        logic [7:0]         pair_three;
        logic               sentence_end;
        logic               restarted;
        logic [7:0]         completed_count;
    } t_result;

endpackage

[rtl/core/nsfp_if.sv]
// valid/ready channel interfaces for characters, results and configuration
interface nsfp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface nsfp_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         group_code;
    logic [7:0]         field_index;
    logic signed [15:0] int_part;
    logic [6:0]         frac_part;
    logic [7:0]         first_char;
    logic [3:0]         field_length;
    logic [7:0]         pair_one;
    logic [7:0]         pair_two;
    logic [7:0]         pair_three;
    logic               sentence_end;
    logic               restarted;
    logic [7:0]         completed_count;

    modport source (output valid, output group_code, output field_index, output int_part,
                    output frac_part, output first_char, output field_length,
                    output pair_one, output pair_two, output pair_three,
                    output sentence_end, output restarted, output completed_count,
                    input ready);
    modport sink   (input valid, input group_code, input field_index, input int_part,
                    input frac_part, input first_char, input field_length,
                    input pair_one, input pair_two, input pair_three,
                    input sentence_end, input restarted, input completed_count,
                    output ready);
endinterface

interface nsfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] group_enable_mask;

    modport source (output valid, output group_enable_mask, input ready);
    modport sink   (input valid, input group_enable_mask, output ready);
endinterface

[rtl/core/nsfp_core.sv]
// parser state and per-character field logic
module nsfp_core
    import nsfp_pkg::*;
#(
    parameter int FIELD_BUFFER_DEPTH = FIELD_BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    input  logic [1:0] i_mask,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int KW_RAW = $clog2(FIELD_BUFFER_DEPTH);
    localparam int KW     = (KW_RAW < 4) ? 4 : KW_RAW;
    localparam logic [KW-1:0] KEEP_LIMIT = KW'(FIELD_BUFFER_DEPTH - 1);
    localparam logic [KW-1:0] HEAD_LIMIT = KW'(HEAD_DEPTH);

    t_phase      r_phase, n_phase;
    logic [KW-1:0] r_kept, n_kept;
    logic [7:0]  r_field_cnt, n_field_cnt;
    t_group      r_group, n_group;
    logic [15:0] r_int, n_int;
    logic [6:0]  r_frac, n_frac;
    t_num_stage  r_stage, n_stage;
    logic        r_neg, n_neg;
    logic [7:0]  r_comp_gga, n_comp_gga;
    logic [7:0]  r_comp_rmc, n_comp_rmc;
    logic [7:0]  r_head [HEAD_DEPTH];

    logic        head_we;
    logic [2:0]  head_idx;
    logic        is_digit;
    logic [3:0]  digit;
    logic        is_delim;
    logic        line_end;
    t_group      grp;
    logic [7:0]  grp_count;

    function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = a - CH_ZERO;
        lo = b - CH_ZERO;
        return 8'((hi << 3) + (hi << 1) + lo);
    endfunction

    function automatic t_group find_group(input logic [KW-1:0] kept, input logic [1:0] mask,
                                          input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2);
        t_group g;
        g = GRP_UNKNOWN;
        if (kept == KW'(3)) begin
            if (mask[0] && c0 == CH_G && c1 == CH_G && c2 == CH_A) begin
                g = GRP_GGA;
            end else if (mask[1] && c0 == CH_R && c1 == CH_M && c2 == CH_C) begin
                g = GRP_RMC;
            end
        end
        return g;
    endfunction

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit    = i_char[3:0];
    assign line_end = (i_char == CH_CR) || (i_char == CH_LF);
    assign is_delim = line_end || (i_char == CH_COMMA) || (i_char == CH_STAR);
    assign head_idx = r_kept[2:0];

    always_comb begin
        n_phase     = r_phase;
        n_kept      = r_kept;
        n_field_cnt = r_field_cnt;
        n_group     = r_group;
        n_int       = r_int;
        n_frac      = r_frac;
        n_stage     = r_stage;
        n_neg       = r_neg;
        n_comp_gga  = r_comp_gga;
        n_comp_rmc  = r_comp_rmc;
        head_we     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        grp         = r_group;
        grp_count   = 8'd0;

        if (i_fire) begin
            case (r_phase)
                PH_WAIT: begin
                    if (i_char == CH_DOLLAR) begin
                        n_phase     = PH_DOLLAR;
                        n_kept      = '0;
                        n_int       = '0;
                        n_frac      = '0;
                        n_stage     = NS_INT;
                        n_neg       = 1'b0;
                        n_field_cnt = 8'd0;
                        n_group     = GRP_UNKNOWN;
                    end
                end
                PH_DOLLAR: begin
                    n_phase = (i_char == CH_G) ? PH_G : PH_WAIT;
                end
                PH_G: begin
                    n_phase = (i_char == CH_P) ? PH_GP : PH_WAIT;
                end
                PH_GP, PH_FIELD: begin
                    if (is_delim) begin
                        // field 0 is the sentence id: it picks the group and gives no result
                        if (r_field_cnt == 8'd0) begin
                            grp = find_group(r_kept, i_mask, r_head[0], r_head[1], r_head[2]);
                        end
                        n_group = grp;
                        case (grp)
                            GRP_GGA: begin
                                grp_count = r_comp_gga + 8'(line_end);
                                n_comp_gga = grp_count;
                            end
                            GRP_RMC: begin
                                grp_count = r_comp_rmc + 8'(line_end);
                                n_comp_rmc = grp_count;
                            end
                            default: begin
                                grp_count = 8'd0;
                            end
                        endcase
                        if (r_field_cnt != 8'd0) begin
                            o_res_valid           = 1'b1;
                            o_res.group_code      = r_group;
                            o_res.field_index     = r_field_cnt;
                            o_res.int_part        = $signed(r_neg ? (16'd0 - r_int) : r_int);
                            o_res.frac_part       = r_frac;
                            o_res.first_char      = (r_kept != '0) ? r_head[0] : 8'd0;
                            o_res.field_length    = r_kept[3:0];
                            o_res.pair_one        = pair_value(r_head[0], r_head[1]);
                            o_res.pair_two        = pair_value(r_head[2], r_head[3]);
                            o_res.pair_three      = pair_value(r_head[4], r_head[5]);
                            o_res.sentence_end    = line_end;
                            o_res.restarted       = 1'b0;
                            o_res.completed_count = grp_count;
                        end
                        n_field_cnt = r_field_cnt + 8'd1;
                        n_kept      = '0;
                        n_int       = '0;
                        n_frac      = '0;
                        n_stage     = NS_INT;
                        n_neg       = 1'b0;
                        n_phase     = line_end ? PH_WAIT : PH_FIELD;
                    end else if (i_char == CH_DOLLAR) begin
                        // restart inside a sentence reports and begins afresh
                        case (r_group)
                            GRP_GGA: grp_count = r_comp_gga;
                            GRP_RMC: grp_count = r_comp_rmc;
                            default: grp_count = 8'd0;
                        endcase
                        o_res_valid           = 1'b1;
                        o_res.group_code      = r_group;
                        o_res.field_index     = r_field_cnt;
                        o_res.restarted       = 1'b1;
                        o_res.completed_count = grp_count;
                        n_phase     = PH_DOLLAR;
                        n_kept      = '0;
                        n_int       = '0;
                        n_frac      = '0;
                        n_stage     = NS_INT;
                        n_neg       = 1'b0;
                        n_field_cnt = 8'd0;
                        n_group     = GRP_UNKNOWN;
                    end else begin
                        n_phase = PH_FIELD;
                        if (r_kept < KEEP_LIMIT) begin
                            head_we = (r_kept < HEAD_LIMIT);
                            n_kept  = r_kept + KW'(1);
                            case (r_stage)
                                NS_INT: begin
                                    if (r_kept == '0 && i_char == CH_MINUS) begin
                                        n_neg = 1'b1;
                                    end else if (is_digit) begin
                                        n_int = 16'((r_int << 3) + (r_int << 1) + {12'd0, digit});
                                    end else if (i_char == CH_DOT) begin
                                        n_stage = NS_FRAC1;
                                    end else begin
                                        n_stage = NS_DONE;
                                    end
                                end
                                NS_FRAC1: begin
                                    if (is_digit) begin
                                        n_frac  = {3'd0, digit};
                                        n_stage = NS_FRAC2;
                                    end else begin
                                        n_stage = NS_DONE;
                                    end
                                end
                                NS_FRAC2: begin
                                    if (is_digit) begin
                                        n_frac = 7'((r_frac << 3) + (r_frac << 1) + {3'd0, digit});
                                    end
                                    n_stage = NS_DONE;
                                end
                                default: begin
                                    n_stage = r_stage;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_kept      <= '0;
            r_field_cnt <= 8'd0;
            r_group     <= GRP_UNKNOWN;
            r_int       <= 16'd0;
            r_frac      <= 7'd0;
            r_stage     <= NS_INT;
            r_neg       <= 1'b0;
            r_comp_gga  <= 8'd0;
            r_comp_rmc  <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_kept      <= n_kept;
            r_field_cnt <= n_field_cnt;
            r_group     <= n_group;
            r_int       <= n_int;
            r_frac      <= n_frac;
            r_stage     <= n_stage;
            r_neg       <= n_neg;
            r_comp_gga  <= n_comp_gga;
            r_comp_rmc  <= n_comp_rmc;
        end
    end

    // first six kept characters, only read where written by the current field or before
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head[head_idx] <= i_char;
        end
    end

    a_keep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= KEEP_LIMIT)
        else $error("kept count beyond field buffer");

    a_restart_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.restarted) |=>
            (r_phase == PH_DOLLAR && r_field_cnt == 8'd0 && r_group == GRP_UNKNOWN))
        else $error("restart did not begin a fresh sentence");

    a_line_end_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.sentence_end) |=> (r_phase == PH_WAIT && r_kept == '0))
        else $error("line end did not return to waiting for start");

    a_unknown_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.group_code == GRP_UNKNOWN) |-> o_res.completed_count == 8'd0)
        else $error("unknown group reports a completion count");

endmodule

[rtl/core/nsfp_result_reg.sv]
// output register holding one result until the sink takes it
module nsfp_result_reg
    import nsfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    nsfp_result_if.source o_result
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid           = r_valid;
    assign o_result.group_code      = r_res.group_code;
    assign o_result.field_index     = r_res.field_index;
    assign o_result.int_part        = r_res.int_part;
    assign o_result.frac_part       = r_res.frac_part;
    assign o_result.first_char      = r_res.first_char;
    assign o_result.field_length    = r_res.field_length;
    assign o_result.pair_one        = r_res.pair_one;
    assign o_result.pair_two        = r_res.pair_two;
    assign o_result.pair_three      = r_res.pair_three;
    assign o_result.sentence_end    = r_res.sentence_end;
    assign o_result.restarted       = r_res.restarted;
    assign o_result.completed_count = r_res.completed_count;

endmodule

[rtl/core/nmea_sentence_field_parser.sv]
// top level of the nmea sentence field parser
//
//   channel    dir  payload              notes
//   i_char     in   char_in[7:0]         one received byte per request
//   o_result   out  field result record  zero or one per character
//   i_cfg      in   group_enable_mask    always ready, write only when idle
//
// one character per cycle sustained while the result register is not stalled; a character
// is accepted into the input register, then parsed into the result register
// the parse step is one pass of the phase and number logic, state updates in place
// a stalled result register holds the input register, which then drops ready
// synchronous active-low reset: waiting for start, counters zero, mask enables both groups
module nmea_sentence_field_parser
    import nsfp_pkg::*;
#(
    parameter int FIELD_BUFFER_DEPTH = FIELD_BUFFER_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nsfp_char_if.sink     i_char,
    nsfp_cfg_if.sink      i_cfg,
    nsfp_result_if.source o_result
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic [1:0] r_mask;
    logic       out_free;
    logic       fire;
    logic       res_valid;
    t_result    res;

    assign fire         = r_in_valid && out_free;
    assign i_char.ready = !r_in_valid || fire;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mask     <= MASK_RESET;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (i_cfg.valid) begin
                r_mask <= i_cfg.group_enable_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_in;
        end
    end

    nsfp_core #(
        .FIELD_BUFFER_DEPTH(FIELD_BUFFER_DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_char     (r_in_char),
        .i_mask     (r_mask),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    nsfp_result_reg u_result_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_result(o_result)
    );

endmodule

[tb/tb_nmea_sentence_field_parser.sv]
// self-checking testbench of the nmea sentence field parser with a bit-level field predictor
module tb_nmea_sentence_field_parser;
    import nsfp_pkg::*;

    localparam int DEPTH          = FIELD_BUFFER_DEPTH_DEF;
    localparam int IDLE_PCT       = 38;
    localparam int DRAIN_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_CHARS    = 360;
    localparam int FLOOD_FIELDS   = 262;

    class field_scoreboard;
        logic [1:0]  mask;
        t_phase      phase;
        int          kept;
        logic [7:0]  fields;
        t_group      grp;
        logic [7:0]  head [HEAD_DEPTH];
        logic [15:0] int_acc;
        logic [6:0]  frac_acc;
        t_num_stage  stage;
        logic        neg;
        logic [7:0]  done_count [2];
        t_result     pending_fields [$];
        int          mismatches;
        int          results_seen;
        int          restarts_seen;
        int          line_ends_seen;

        function new();
            mask  = MASK_RESET;
            phase = PH_WAIT;
            foreach (head[i]) head[i] = '0;
            done_count[0] = '0;
            done_count[1] = '0;
            mismatches     = 0;
            results_seen   = 0;
            restarts_seen  = 0;
            line_ends_seen = 0;
            start_sentence();
        endfunction

        function void set_mask(logic [1:0] m);
            mask = m;
        endfunction

        function void clear_field();
            kept     = 0;
            int_acc  = '0;
            frac_acc = '0;
            stage    = NS_INT;
            neg      = 1'b0;
        endfunction

        function void start_sentence();
            clear_field();
            fields = '0;
            grp    = GRP_UNKNOWN;
        endfunction

        function logic [7:0] group_count();
            if (grp == GRP_GGA) return done_count[0];
            if (grp == GRP_RMC) return done_count[1];
            return '0;
        endfunction

        function logic [7:0] pair(logic [7:0] a, logic [7:0] b);
            return (a - CH_ZERO) * 8'd10 + (b - CH_ZERO);
        endfunction

        function t_group id_group();
            if (kept != 3) return GRP_UNKNOWN;
            if (mask[0] && head[0] == CH_G && head[1] == CH_G && head[2] == CH_A)
                return GRP_GGA;
            if (mask[1] && head[0] == CH_R && head[1] == CH_M && head[2] == CH_C)
                return GRP_RMC;
            return GRP_UNKNOWN;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void keep_char(logic [7:0] c);
            if (kept < HEAD_DEPTH) head[kept] = c;
            case (stage)
                NS_INT: begin
                    if (kept == 0 && c == CH_MINUS) neg = 1'b1;
                    else if (is_digit(c)) int_acc = int_acc * 16'd10 + 16'(c - CH_ZERO);
                    else if (c == CH_DOT) stage = NS_FRAC1;
                    else stage = NS_DONE;
                end
                NS_FRAC1: begin
                    if (is_digit(c)) begin
                        frac_acc = 7'(c - CH_ZERO);
                        stage    = NS_FRAC2;
                    end else begin
                        stage = NS_DONE;
                    end
                end
                NS_FRAC2: begin
                    if (is_digit(c)) frac_acc = frac_acc * 7'd10 + 7'(c - CH_ZERO);
                    stage = NS_DONE;
                end
                default: ;
            endcase
            kept++;
        endfunction

        // one accepted character: advance the parse and queue the result it causes
        function void note_char(logic [7:0] c);
            t_result r;
            logic    line_end;
            if (phase == PH_WAIT) begin
                if (c == CH_DOLLAR) begin
                    phase = PH_DOLLAR;
                    start_sentence();
                end
                return;
            end
            if (phase == PH_DOLLAR) begin
                phase = (c == CH_G) ? PH_G : PH_WAIT;
                return;
            end
            if (phase == PH_G) begin
                phase = (c == CH_P) ? PH_GP : PH_WAIT;
                return;
            end
            r = '0;
            if (c == CH_COMMA || c == CH_STAR || c == CH_CR || c == CH_LF) begin
                line_end = (c == CH_CR || c == CH_LF);
                if (fields == 0) grp = id_group();
                if (line_end) begin
                    line_ends_seen++;
                    if (grp == GRP_GGA) done_count[0]++;
                    else if (grp == GRP_RMC) done_count[1]++;
                end
                if (fields != 0) begin
                    r.group_code      = grp;
                    r.field_index     = fields;
                    r.int_part        = neg ? -int_acc : int_acc;
                    r.frac_part       = frac_acc;
                    r.first_char      = (kept > 0) ? head[0] : 8'd0;
                    r.field_length    = 4'(kept);
                    r.pair_one        = pair(head[0], head[1]);
                    r.pair_two        = pair(head[2], head[3]);
                    r.pair_three      = pair(head[4], head[5]);
                    r.sentence_end    = line_end;
                    r.completed_count = group_count();
                    pending_fields.push_back(r);
                end
                fields++;
                clear_field();
                phase = line_end ? PH_WAIT : PH_FIELD;
                return;
            end
            if (c == CH_DOLLAR) begin
                // dollar inside a sentence: report, then begin afresh after the dollar
                r.group_code      = grp;
                r.field_index     = fields;
                r.restarted       = 1'b1;
                r.completed_count = group_count();
                pending_fields.push_back(r);
                restarts_seen++;
                phase = PH_DOLLAR;
                start_sentence();
                return;
            end
            if (kept < DEPTH - 1) keep_char(c);
            phase = PH_FIELD;
        endfunction

        function string show(t_result r);
            return $sformatf({"grp %0d idx %0d int %0d frac %0d first %h len %0d ",
                              "pairs %0d %0d %0d end %b rst %b cnt %0d"},
                             r.group_code, r.field_index, $signed(r.int_part), r.frac_part,
                             r.first_char, r.field_length, r.pair_one, r.pair_two,
                             r.pair_three, r.sentence_end, r.restarted, r.completed_count);
        endfunction

        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (pending_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no field pending: %s", show(got));
                return;
            end
            want = pending_fields.pop_front();
            if (got.group_code !== want.group_code || got.field_index !== want.field_index ||
                got.int_part !== want.int_part || got.frac_part !== want.frac_part ||
                got.first_char !== want.first_char || got.field_length !== want.field_length ||
                got.pair_one !== want.pair_one || got.pair_two !== want.pair_two ||
                got.pair_three !== want.pair_three || got.sentence_end !== want.sentence_end ||
                got.restarted !== want.restarted ||
                got.completed_count !== want.completed_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("field result mismatch at result %0d", results_seen);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady;
    int   chars_sent;

    nsfp_char_if   chr();
    nsfp_cfg_if    cfg();
    nsfp_result_if res();

    field_scoreboard sb = new();

    nmea_sentence_field_parser #(
        .FIELD_BUFFER_DEPTH(DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chr),
        .i_cfg   (cfg),
        .o_result(res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && chr.valid && chr.ready) sb.note_char(chr.char_in);
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && res.valid && res.ready) begin
            got.group_code      = t_group'(res.group_code);
            got.field_index     = res.field_index;
            got.int_part        = res.int_part;
            got.frac_part       = res.frac_part;
            got.first_char      = res.first_char;
            got.field_length    = res.field_length;
            got.pair_one        = res.pair_one;
            got.pair_two        = res.pair_two;
            got.pair_three      = res.pair_three;
            got.sentence_end    = res.sentence_end;
            got.restarted       = res.restarted;
            got.completed_count = res.completed_count;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_char(input logic [7:0] c);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            chr.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        chr.valid   <= 1'b1;
        chr.char_in <= c;
        do @(posedge i_clk); while (!(chr.valid && chr.ready));
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_upper();
        return CH_A + 8'($urandom_range(25));
    endfunction

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
    endtask

    // wait until every queued result is back and the pipeline is empty
    task automatic drain();
        chr.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_fields.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [1:0] m);
        cfg.valid             <= 1'b1;
        cfg.group_enable_mask <= m;
        do @(posedge i_clk); while (!(cfg.valid && cfg.ready));
        cfg.valid <= 1'b0;
        sb.set_mask(m);
    endtask

    task automatic send_field();
        case ($urandom_range(9))
            0: ;
            1, 2, 3: begin
                if ($urandom_range(3) == 0) send_char(CH_MINUS);
                repeat ($urandom_range(0, 7)) send_char(rand_digit());
                if ($urandom_range(1)) begin
                    send_char(CH_DOT);
                    repeat ($urandom_range(0, 3)) send_char(rand_digit());
                end
            end
            4, 5: begin
                repeat (6) send_char(rand_digit());
                if ($urandom_range(1)) begin
                    send_char(CH_DOT);
                    send_char(rand_digit());
                    send_char(rand_digit());
                end
            end
            6: send_char(rand_upper());
            7: repeat ($urandom_range(14, 22)) send_char(8'($urandom_range(8'h30, 8'h5A)));
            default: repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)));
        endcase
    endtask

    // everything after "$": header rest, id and fields; again set when a dollar restarted it
    task automatic send_body(output bit again);
        again = 1'b0;
        send_char(CH_G);
        send_char(CH_P);
        case ($urandom_range(9))
            0, 1, 2, 3: send_text("GGA");
            4, 5, 6, 7: send_text("RMC");
            8: begin
                send_char(CH_G);
                send_char(CH_G);
                send_char(rand_upper());
            end
            default: repeat ($urandom_range(0, 5)) send_char(rand_upper());
        endcase
        repeat ($urandom_range(0, 14)) begin
            send_char(($urandom_range(99) < 88) ? CH_COMMA : CH_STAR);
            if ($urandom_range(99) < 3) begin
                send_char(CH_DOLLAR);
                again = 1'b1;
                return;
            end
            send_field();
        end
        // a quarter are left open so that the next dollar restarts them
        if ($urandom_range(99) < 75) begin
            if ($urandom_range(1)) begin
                send_char(CH_STAR);
                send_char(rand_digit());
                send_char(rand_upper());
            end
            case ($urandom_range(2))
                0: send_char(CH_CR);
                1: send_char(CH_LF);
                default: begin
                    send_char(CH_CR);
                    send_char(CH_LF);
                end
            endcase
        end
    endtask

    task automatic send_sentence();
        int pick;
        bit again;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_noise();
            return;
        end
        send_char(CH_DOLLAR);
        if (pick < 16) begin
            // broken header after the dollar or after the G
            if ($urandom_range(1)) send_char(CH_G);
            send_char(8'($urandom_range(255)));
            return;
        end
        do send_body(again); while (again);
    endtask

    // enough fields in one sentence to wrap the field counter
    task automatic send_field_flood();
        send_text("$GPGGA");
        repeat (FLOOD_FIELDS) begin
            send_char(CH_COMMA);
            if ($urandom_range(3) == 0) send_char(rand_digit());
        end
        send_char(CH_LF);
    endtask

    task automatic send_directed();
        send_char(8'h00);
        send_char(8'hFF);
        send_text("$GX");
        // six-character id writes every head entry before any field result
        send_text("$GPRMC123,");
        send_text("-1.25,");
        send_text("$GPGGA,");
        send_char(CH_CR);
    endtask

    initial begin : stimulus
        logic [1:0] phase_masks [4];
        int target;
        phase_masks = '{2'b01, 2'b10, 2'b00, 2'b11};
        chr.valid             = 1'b0;
        chr.char_in           = '0;
        cfg.valid             = 1'b0;
        cfg.group_enable_mask = MASK_RESET;
        i_rst_n               = 1'b0;
        steady                = 1'b0;
        chars_sent            = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mask(MASK_RESET);
        send_directed();
        drain();

        foreach (phase_masks[p]) begin
            write_mask(phase_masks[p]);
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target) begin
                // no idling on either side through the middle of the second phase
                steady = (p == 1) && (chars_sent > target - 2 * PHASE_CHARS / 3) &&
                         (chars_sent < target - PHASE_CHARS / 3);
                send_sentence();
            end
            steady = 1'b0;
            if (phase_masks[p] == 2'b11) send_field_flood();
            drain();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run covered %0d characters, %0d field results, %0d restarts, %0d line ends",
                 chars_sent, sb.results_seen, sb.restarts_seen, sb.line_ends_seen);
        $display("group masks 3, 1, 2, 0, 3 with a field counter wrap");
        if (sb.mismatches == 0 && sb.pending_fields.size() == 0) begin
            $display("** nmea_sentence_field_parser: PASSED **");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("** nmea_sentence_field_parser: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout with %0d results pending", sb.pending_fields.size());
        $display("** nmea_sentence_field_parser: FAILED **");
        $finish;
    end

endmodule
